/* rtl/core/sliding_window_progress_check_core_defines.svh */
// Assertion macros shared by the progress check RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef SLIDING_WINDOW_PROGRESS_CHECK_CORE_DEFINES_SVH
`define SLIDING_WINDOW_PROGRESS_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWPC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swpc assertion failed");

// Next-cycle implication, disabled during reset.
`define SWPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swpc assertion failed");

`endif

/* rtl/core/swpc_pkg.sv */
// Package for the sliding window progress check: sizes, codes, types.
// No dependencies; imported by every module of the block.
package swpc_pkg;

   localparam int WINDOW_MAX = 128;
   localparam int COORD_BITS = 24;

   localparam int LEN_BITS      = 8;
   localparam int MM_BITS       = 32;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 32;

   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int RAD_BITS  = 2 * COORD_BITS + 2;
   localparam int ROOT_BITS = COORD_BITS + 1;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int SQ_STEPS  = ROOT_BITS;
   localparam int STEP_BITS = $clog2(SQ_STEPS + 1);

   localparam int IDX_BITS  = $clog2(WINDOW_MAX);
   localparam int FILL_BITS = $clog2(WINDOW_MAX + 1);
   localparam int SUM_RAW   = ROOT_BITS + $clog2(WINDOW_MAX) + 1;
   localparam int SUM_BITS  = (SUM_RAW > MM_BITS) ? SUM_RAW : MM_BITS + 1;

   localparam int REQ_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((1 + MM_BITS + 7) / 8) * 8;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_WINDOW_LEN = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_MIN_TRAVEL = 1'd1;

   localparam logic [LEN_BITS-1:0] WINDOW_LEN_RST = 8'd100;
   localparam logic [MM_BITS-1:0]  MIN_TRAVEL_RST = 32'd250;

   // request kinds
   localparam logic REQ_PUSH  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } pos_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] seg;
   } seg_res_type;

   typedef struct packed {
      logic                 push;
      logic                 clear;
      logic [ROOT_BITS-1:0] seg;
      logic [FILL_BITS-1:0] len;
   } win_cmd_type;

   typedef struct packed {
      logic                done;
      logic                full;
      logic [SUM_BITS-1:0] sum;
   } win_stat_type;

   // window length as used: zero counts as one, capped at the ring depth
   function automatic logic [FILL_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
      int unsigned v;
      v = len;
      if (v == 0) v = 1;
      if (v > WINDOW_MAX) v = WINDOW_MAX;
      return FILL_BITS'(v);
   endfunction

endpackage

/* rtl/core/swpc_isqrt.sv */
// Digit-serial floor square root: two radicand bits in, one root bit out per cycle.
// Depends on swpc_pkg.
module swpc_isqrt import swpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_BITS-1:0]  radicand,
   output logic                 done,
   output logic [ROOT_BITS-1:0] root
);

   logic [RAD_BITS-1:0]  rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [REM_BITS-1:0] rem_sh;
   logic [REM_BITS-1:0] trial;
   logic                ge;

   always_comb begin
      rem_sh  = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
      trial   = {root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = STEP_BITS'(SQ_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_BITS-3:0], 2'b00};
         rem_in  = ge ? rem_sh - trial : rem_sh;
         root_in = {root_ff[ROOT_BITS-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/core/swpc_seglen.sv */
// Segment length unit: absolute deltas, shared squaring multiplier, then isqrt.
// Depends on swpc_pkg and swpc_isqrt.
module swpc_seglen import swpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  pos_type     cur,
   input  pos_type     prev,
   output seg_res_type res
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_ROOT = 2'd2;
   localparam logic [1:0] S_WAIT = 2'd3;

   localparam logic [1:0] AX_X    = 2'd0;
   localparam logic [1:0] AX_Y    = 2'd1;
   localparam logic [1:0] AX_Z    = 2'd2;
   localparam logic [1:0] AX_LAST = 2'd3;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      if (d[COORD_BITS]) d = -d;
      return d[COORD_BITS-1:0];
   endfunction

   logic [1:0]            state_ff, state_in;
   logic [1:0]            step_ff, step_in;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_BITS-1:0]    prod_ff, prod_in;
   logic [RAD_BITS-1:0]   acc_ff, acc_in;
   logic [COORD_BITS-1:0] sel;
   logic                  root_go;
   logic                  root_done;
   logic [ROOT_BITS-1:0]  root_val;

   always_comb begin
      case (step_ff)
         AX_X:    sel = dx_ff;
         AX_Y:    sel = dy_ff;
         default: sel = dz_ff;
      endcase
      prod_in  = SQ_BITS'(sel) * SQ_BITS'(sel);
      acc_in   = acc_ff;
      step_in  = step_ff;
      state_in = state_ff;
      root_go  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               step_in  = AX_X;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            acc_in  = (step_ff == AX_X) ? '0 : acc_ff + RAD_BITS'(prod_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == AX_LAST) state_in = S_ROOT;
         end
         S_ROOT: begin
            root_go  = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (root_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == S_IDLE) begin
         dx_ff <= abs_diff(cur.x, prev.x);
         dy_ff <= abs_diff(cur.y, prev.y);
         dz_ff <= abs_diff(cur.z, prev.z);
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   swpc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_go),
      .radicand (acc_ff),
      .done     (root_done),
      .root     (root_val)
   );

   assign res.done = root_done;
   assign res.seg  = root_val;

endmodule

/* rtl/core/swpc_window.sv */
// Segment window: ring of segment lengths, fill/head tracking, running sum
// with evictions one at a time via W_RD and W_SUB. Depends on swpc_pkg.
module swpc_window import swpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  win_cmd_type  cmd,
   output win_stat_type stat
);

   localparam logic [1:0] W_IDLE = 2'd0;
   localparam logic [1:0] W_RD   = 2'd1;
   localparam logic [1:0] W_SUB  = 2'd2;

   localparam logic [IDX_BITS-1:0] IDX_TOP = IDX_BITS'(WINDOW_MAX - 1);

   logic [ROOT_BITS-1:0] seg_mem [WINDOW_MAX];
   logic [ROOT_BITS-1:0] rd_ff;

   logic [1:0]           state_ff, state_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [IDX_BITS-1:0]  head_ff, head_in;
   logic [IDX_BITS-1:0]  ptr_ff, ptr_in;
   logic [FILL_BITS-1:0] cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic                 done_ff, done_in;
   logic                 full_ff, full_in;

   logic [ROOT_BITS-1:0] seg_eff;
   logic [FILL_BITS-1:0] fill_inc, fill_new;
   logic [FILL_BITS:0]   drop;
   logic [IDX_BITS-1:0]  back;
   logic                 wr_en;

   always_comb begin
      seg_eff  = (fill_ff == '0) ? '0 : cmd.seg;
      fill_inc = (fill_ff < FILL_BITS'(WINDOW_MAX)) ? fill_ff + 1'b1 : fill_ff;
      fill_new = (fill_inc > cmd.len) ? cmd.len : fill_inc;
      drop     = {1'b0, fill_ff} + 1'b1 - {1'b0, fill_new};
      back     = IDX_BITS'(fill_new - 1'b1);

      state_in = state_ff;
      fill_in  = fill_ff;
      head_in  = head_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      full_in  = full_ff;
      done_in  = 1'b0;
      wr_en    = 1'b0;

      case (state_ff)
         W_IDLE: begin
            if (cmd.clear) begin
               fill_in = '0;
               sum_in  = '0;
            end else if (cmd.push) begin
               wr_en   = 1'b1;
               fill_in = fill_new;
               sum_in  = sum_ff + SUM_BITS'(seg_eff);
               head_in = (head_ff == IDX_TOP) ? '0 : head_ff + 1'b1;
               full_in = (fill_new == cmd.len);
               // oldest segment still kept sits fill_new-1 slots behind the new one
               ptr_in  = (head_ff >= back) ? head_ff - back
                                           : IDX_BITS'({1'b0, head_ff} + (IDX_BITS+1)'(WINDOW_MAX)
                                                       - {1'b0, back});
               cnt_in  = drop[FILL_BITS-1:0];
               if (drop == '0) done_in = 1'b1;
               else            state_in = W_RD;
            end
         end
         W_RD: state_in = W_SUB;
         W_SUB: begin
            sum_in = sum_ff - SUM_BITS'(rd_ff);
            ptr_in = (ptr_ff == '0) ? IDX_TOP : ptr_ff - 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == FILL_BITS'(1)) begin
               done_in  = 1'b1;
               state_in = W_IDLE;
            end else begin
               state_in = W_RD;
            end
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) seg_mem[head_ff] <= seg_eff;
      rd_ff <= seg_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      cnt_ff  <= cnt_in;
      full_ff <= full_in;
      if (reset) begin
         state_ff <= W_IDLE;
         fill_ff  <= '0;
         head_ff  <= '0;
         sum_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
         sum_ff   <= sum_in;
         done_ff  <= done_in;
      end
   end

   assign stat.done = done_ff;
   assign stat.full = full_ff;
   assign stat.sum  = sum_ff;

endmodule

/* rtl/core/sliding_window_progress_check_core.sv */
// Sliding window progress check (stuck detector) for a moving robot. Every
// request transfer gives exactly one response transfer. A clear request empties
// the window and answers progress with 0 mm. A push request appends a
// position: the segment from the previous position is measured (abs deltas, three
// squares through one shared multiplier, then a digit-serial square root that
// yields one root bit per cycle), the window sum is updated and the oldest
// segments are dropped from it one at a time through the ring read port.
// A push evicts no position while the window fills, one once it is full, and
// every surplus position after window_len was lowered; the square root runs
// 25 steps. One request is in work at a time; a finished result sits in the
// output register so the next request can be taken while it waits. While the
// window is not full the answer is progress with 0 mm; once full, travelled_mm
// is the saturated segment sum and progress means it is above min_travel_mm.
// Registers may be written only while the block is idle.
// Depends on swpc_pkg, swpc_seglen, swpc_isqrt and swpc_window.
`include "sliding_window_progress_check_core_defines.svh"

module sliding_window_progress_check_core import swpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // pos_x, pos_y, pos_z
   input  logic                     req_tuser,   // req_type
   // response channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // making_progress, travelled_mm, zero pad
   // register writes
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_SEG  = 2'd1;   // segment length in work
   localparam logic [1:0] T_WIN  = 2'd2;   // window update in work
   localparam logic [1:0] T_OUT  = 2'd3;   // result ready, waiting for output slot

   logic [1:0]          state_ff, state_in;
   logic [LEN_BITS-1:0] window_len_ff;
   logic [MM_BITS-1:0]  min_travel_ff;
   pos_type             last_pos_ff;
   pos_type             cur_pos;

   logic                pend_prog_ff, pend_prog_in;
   logic [MM_BITS-1:0]  pend_mm_ff, pend_mm_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_prog_ff;
   logic [MM_BITS-1:0]  rsp_mm_ff;

   logic                accept;
   logic                load_rsp;
   logic                seg_go;
   seg_res_type         seg_res;
   win_cmd_type         win_cmd;
   win_stat_type        win_stat;
   logic [MM_BITS-1:0]  sum_sat;

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign cur_pos.x = req_tdata[COORD_BITS-1:0];
   assign cur_pos.y = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign cur_pos.z = req_tdata[3*COORD_BITS-1:2*COORD_BITS];

   assign seg_go = accept && (req_tuser == REQ_PUSH);

   // window control: clear on a clear transfer, push when the segment is measured
   always_comb begin
      win_cmd.clear = accept && (req_tuser == REQ_CLEAR);
      win_cmd.push  = (state_ff == T_SEG) && seg_res.done;
      win_cmd.seg   = seg_res.seg;
      win_cmd.len   = eff_len(window_len_ff);
   end

   // travel saturates at the top of the 32-bit range
   assign sum_sat = (|win_stat.sum[SUM_BITS-1:MM_BITS]) ? '1 : win_stat.sum[MM_BITS-1:0];

   assign load_rsp = (state_ff == T_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      pend_prog_in = pend_prog_ff;
      pend_mm_in   = pend_mm_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (req_tuser == REQ_CLEAR) begin
                  pend_prog_in = 1'b1;
                  pend_mm_in   = '0;
                  state_in     = T_OUT;
               end else begin
                  state_in = T_SEG;
               end
            end
         end
         T_SEG: begin
            if (seg_res.done) state_in = T_WIN;
         end
         T_WIN: begin
            if (win_stat.done) begin
               pend_prog_in = win_stat.full ? (sum_sat > min_travel_ff) : 1'b1;
               pend_mm_in   = win_stat.full ? sum_sat : '0;
               state_in     = T_OUT;
            end
         end
         T_OUT: begin
            if (load_rsp) state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      pend_prog_ff <= pend_prog_in;
      pend_mm_ff   <= pend_mm_in;
      if (seg_go) last_pos_ff <= cur_pos;
      if (load_rsp) begin
         rsp_prog_ff <= pend_prog_ff;
         rsp_mm_ff   <= pend_mm_ff;
      end
      if (reset) begin
         state_ff      <= T_IDLE;
         rsp_valid_ff  <= 1'b0;
         window_len_ff <= WINDOW_LEN_RST;
         min_travel_ff <= MIN_TRAVEL_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               REG_WINDOW_LEN: window_len_ff <= csr_wdata[LEN_BITS-1:0];
               REG_MIN_TRAVEL: min_travel_ff <= csr_wdata[MM_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   swpc_seglen u_seglen (
      .clock (clock),
      .reset (reset),
      .start (seg_go),
      .cur   (cur_pos),
      .prev  (last_pos_ff),
      .res   (seg_res)
   );

   swpc_window u_window (
      .clock (clock),
      .reset (reset),
      .cmd   (win_cmd),
      .stat  (win_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_mm_ff, rsp_prog_ff});

   // one request in work at a time
   `SWPC_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   // segment results only while waiting for one
   `SWPC_ASSERT_NOW(a_seg_done_in_seg, clock, reset, seg_res.done, state_ff == T_SEG)
   // window completion only while waiting for it
   `SWPC_ASSERT_NOW(a_win_done_in_win, clock, reset, win_stat.done, state_ff == T_WIN)
   // a finished result reaches the output register once the slot is free
   `SWPC_ASSERT_NEXT(a_result_loaded, clock, reset, state_ff == T_OUT && !rsp_valid_ff,
                     rsp_valid_ff)

endmodule

/* verif/sliding_window_progress_check_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_progress_check_core: push/clear streams
// with random stalls, checked by a window-travel scoreboard class.
// Depends on swpc_pkg and the core RTL; reads no files.
module sliding_window_progress_check_core_tb;
   import swpc_pkg::*;

   localparam int     WATCHDOG_LIMIT = 4000;   // worst push evicts the whole ring
   localparam int     TOTAL_ITEMS    = 800;
   localparam int     QUIET_TAIL     = 100;    // last transfers run with no idling
   localparam int     ANS_DEPTH      = 16;     // predictions owed never exceed a few
   localparam longint COORD_MIN      = -(longint'(1) << (COORD_BITS - 1));
   localparam longint COORD_MAX      = (longint'(1) << (COORD_BITS - 1)) - 1;

   typedef struct {
      logic               progress;
      logic [MM_BITS-1:0] travel;
   } answer_type;

   // Scoreboard: keeps its own copy of the window and registers, predicts one
   // answer per accepted request and compares answers in order.
   class window_travel_board;
      logic [LEN_BITS-1:0] win_len;
      logic [MM_BITS-1:0]  min_travel;
      pos_type             positions [WINDOW_MAX];
      longint unsigned     seg_lens  [WINDOW_MAX];
      int unsigned         filled;
      int unsigned         head;
      answer_type          ans_ring [ANS_DEPTH];
      int unsigned         ans_wr;
      int unsigned         ans_rd;
      int unsigned         mismatches;
      int unsigned         answers_checked;

      function new();
         win_len         = WINDOW_LEN_RST;
         min_travel      = MIN_TRAVEL_RST;
         filled          = 0;
         head            = 0;
         ans_wr          = 0;
         ans_rd          = 0;
         mismatches      = 0;
         answers_checked = 0;
      endfunction

      // predictions still owed by the block
      function int unsigned pending();
         return ans_wr - ans_rd;
      endfunction

      function void store_answer(answer_type a);
         ans_ring[ans_wr % ANS_DEPTH] = a;
         ans_wr++;
      endfunction

      function answer_type take_answer();
         answer_type a;
         a = ans_ring[ans_rd % ANS_DEPTH];
         ans_rd++;
         return a;
      endfunction

      function void write_reg(logic [CSR_ADDR_BITS-1:0] addr,
                              logic [CSR_DATA_BITS-1:0] data);
         if (addr == REG_WINDOW_LEN)
            win_len = data[LEN_BITS-1:0];
         else if (addr == REG_MIN_TRAVEL)
            min_travel = data[MM_BITS-1:0];
      endfunction

      // floor square root, building the root from the top bit down
      function longint unsigned floor_root(longint unsigned v);
         longint unsigned r;
         longint unsigned t;
         r = 0;
         for (int b = 27; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function longint unsigned segment_mm(pos_type a, pos_type b);
         longint dx;
         longint dy;
         longint dz;
         dx = longint'(a.x) - longint'(b.x);
         dy = longint'(a.y) - longint'(b.y);
         dz = longint'(a.z) - longint'(b.z);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         if (dz < 0) dz = -dz;
         return floor_root(dx * dx + dy * dy + dz * dz);
      endfunction

      function void note_request(logic kind, pos_type p);
         int unsigned     eff;
         longint unsigned seg;
         longint unsigned sum;
         answer_type      a;
         eff = win_len;
         if (eff == 0) eff = 1;
         if (eff > WINDOW_MAX) eff = WINDOW_MAX;
         a.progress = 1'b1;
         a.travel   = '0;
         if (kind == REQ_CLEAR) begin
            filled = 0;
            store_answer(a);
            return;
         end
         seg = 0;
         if (filled > 0)
            seg = segment_mm(positions[(head + WINDOW_MAX - 1) % WINDOW_MAX], p);
         positions[head] = p;
         seg_lens[head]  = seg;
         head = (head + 1) % WINDOW_MAX;
         if (filled < WINDOW_MAX) filled++;
         // a lowered window drops the surplus oldest entries here
         if (filled > eff) filled = eff;
         if (filled >= eff) begin
            sum = 0;
            // the oldest entry's segment reaches outside the window: skip it
            for (int k = 0; k + 1 < filled; k++)
               sum += seg_lens[(head + 2 * WINDOW_MAX - 1 - k) % WINDOW_MAX];
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            a.progress = (sum > min_travel);
            a.travel   = sum[MM_BITS-1:0];
         end
         store_answer(a);
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_response(logic [RSP_DATA_BITS-1:0] data);
         answer_type want;
         if (pending() == 0) begin
            report($sformatf("response %h with no transfer pending", data));
            return;
         end
         want = take_answer();
         answers_checked++;
         if (data[0] !== want.progress)
            report($sformatf("making_progress %b, want %b (answer %0d)",
                             data[0], want.progress, answers_checked));
         if (data[MM_BITS:1] !== want.travel)
            report($sformatf("travelled_mm %0d, want %0d (answer %0d)",
                             data[MM_BITS:1], want.travel, answers_checked));
      endtask
   endclass

   // DUT-facing signals; every input starts at a known value
   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // pos_x, pos_y, pos_z
   logic                     req_tuser  = 1'b0; // req_type
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // making_progress, travelled_mm, zero pad
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   window_travel_board board;

   int unsigned items_sent     = 0;
   int unsigned pushes         = 0;
   int unsigned clears         = 0;
   int unsigned csr_writes     = 0;
   int unsigned stalled_cycles = 0;
   int unsigned send_odds      = 0;   // 1-in-N chance of a sender gap, 0 = never
   int unsigned ready_odds     = 0;   // 1-in-N chance of a receiver stall, 0 = never
   int unsigned ready_hold     = 0;
   bit          quiet_tail     = 1'b0;
   longint      cur_x = 0;
   longint      cur_y = 0;
   longint      cur_z = 0;

   sliding_window_progress_check_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: check each transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata);
   end

   // receiver backpressure: random stall bursts
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if (!quiet_tail && ready_odds != 0 && $urandom_range(1, ready_odds) == 1) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: too long with no transfer on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d answers outstanding",
                  stalled_cycles, board.pending());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   function automatic longint clamp_coord(longint v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic longint rand_coord();
      return longint'($urandom_range(0, (1 << COORD_BITS) - 1)) + COORD_MIN;
   endfunction

   // one request transfer; valid stays up into the next item unless a gap is drawn
   task automatic send_item(input logic kind, input longint x, input longint y,
                            input longint z);
      pos_type p;
      p.x = x[COORD_BITS-1:0];
      p.y = y[COORD_BITS-1:0];
      p.z = z[COORD_BITS-1:0];
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, p);
      items_sent++;
      if (kind == REQ_CLEAR) clears++;
      else pushes++;
      if (!quiet_tail && send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic push_at(input longint x, input longint y, input longint z);
      cur_x = x;
      cur_y = y;
      cur_z = z;
      send_item(REQ_PUSH, x, y, z);
   endtask

   // robot motion: a bounded random offset on each axis
   task automatic push_step(input int unsigned reach);
      push_at(clamp_coord(cur_x + longint'($urandom_range(0, 2 * reach)) - reach),
              clamp_coord(cur_y + longint'($urandom_range(0, 2 * reach)) - reach),
              clamp_coord(cur_z + longint'($urandom_range(0, 2 * reach)) - reach));
   endtask

   // registers change only with the block idle: nothing owed, nothing in flight
   task automatic drain_to_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_BITS-1:0] len_word,
                               input logic [CSR_DATA_BITS-1:0] travel_word);
      csr_we    <= 1'b1;
      csr_addr  <= REG_WINDOW_LEN;
      csr_wdata <= len_word;
      @(posedge clock);
      board.write_reg(REG_WINDOW_LEN, len_word);
      csr_addr  <= REG_MIN_TRAVEL;
      csr_wdata <= travel_word;
      @(posedge clock);
      board.write_reg(REG_MIN_TRAVEL, travel_word);
      csr_we     <= 1'b0;
      csr_writes += 2;
   endtask

   initial begin
      int unsigned   phase;
      int unsigned   phase_len;
      int unsigned   roll;
      int unsigned   eff;
      int unsigned   reach;
      logic [7:0]    len_byte;
      logic [31:0]   thr;

      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send_odds  = 3;
      ready_odds = 4;
      // reset window of 100 is far from full: progress with 0 mm
      push_at(100, -200, 300);
      // clear ignores its position fields
      send_item(REQ_CLEAR, COORD_MAX, COORD_MIN, 5);

      // zero length acts as one: every push is a full window with 0 mm travel
      drain_to_idle();
      program_regs(32'd0, 32'd0);
      push_at(COORD_MAX, COORD_MAX, COORD_MAX);
      push_at(COORD_MIN, COORD_MIN, COORD_MIN);

      // two-entry window, unreachable threshold; corner-to-corner segment
      drain_to_idle();
      program_regs(32'd2, 32'hFFFF_FFFF);
      send_item(REQ_CLEAR, 0, 0, 0);
      push_at(COORD_MIN, COORD_MIN, COORD_MIN);   // first after clear: no segment
      push_at(COORD_MAX, COORD_MAX, COORD_MAX);
      push_at(COORD_MAX, COORD_MAX, COORD_MAX);   // standing still

      drain_to_idle();
      program_regs(32'd2, 32'd0);
      push_at(COORD_MAX, COORD_MIN, 0);
      push_at(COORD_MAX, COORD_MIN, 0);           // 0 mm against a zero threshold

      // three-entry window: exact roots and the equal-to-threshold edge
      drain_to_idle();
      program_regs(32'd3, 32'd5);
      send_item(REQ_CLEAR, COORD_MIN, COORD_MAX, COORD_MIN);
      push_at(0, 0, 0);
      push_at(3, 4, 0);
      push_at(3, 4, 5);                           // 5 + 5 = 10 > 5
      push_at(3, 4, 5);                           // 5 + 0 = 5, not above
      push_at(4, 5, 6);                           // floor(sqrt(3)) = 1

      // length above the ring depth saturates to the ring depth
      drain_to_idle();
      program_regs(32'h5A5A_5AC8, $urandom());
      push_step(1000);
      push_step(1000);

      // ---- random part: phases of well-formed motion with clears and noise ----
      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         drain_to_idle();
         if (phase == 0)
            len_byte = 8'd128;                    // fill the whole ring ...
         else if (phase == 1)
            len_byte = 8'd5;                      // ... then shrink it while full
         else begin
            case ($urandom_range(0, 15))
               0:       len_byte = 8'd0;
               1:       len_byte = 8'd128;
               2:       len_byte = 8'($urandom_range(129, 255));
               3:       len_byte = 8'd100;
               4:       len_byte = 8'd1;
               5:       len_byte = 8'($urandom_range(17, 40));
               default: len_byte = 8'($urandom_range(2, 16));
            endcase
         end
         eff = (len_byte == 0) ? 1 : (len_byte > WINDOW_MAX) ? WINDOW_MAX : len_byte;
         case ($urandom_range(0, 4))
            0:       reach = 0;                   // truly stuck
            1:       reach = 2;
            2:       reach = 60;
            3:       reach = 1500;
            default: reach = 30000;
         endcase
         case ($urandom_range(0, 5))
            0:       thr = 32'd0;
            1:       thr = 32'hFFFF_FFFF;
            2:       thr = $urandom();
            default: thr = $urandom_range(0, eff * reach + 1);
         endcase
         // upper bits of the length word are don't-care and get random values
         program_regs(($urandom() & 32'hFFFF_FF00) | len_byte, thr);
         send_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         ready_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);

         if (phase != 1 && $urandom_range(0, 1) == 1)
            send_item(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord());
         phase_len = eff + $urandom_range(4, 40);
         for (int i = 0; i < phase_len && items_sent < TOTAL_ITEMS; i++) begin
            quiet_tail = (items_sent >= TOTAL_ITEMS - QUIET_TAIL);
            roll = $urandom_range(0, 99);
            if (roll < 4)
               send_item(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord());
            else if (roll < 10)
               push_at(rand_coord(), rand_coord(), rand_coord());   // teleport noise
            else
               push_step(reach);
         end
         phase++;
      end

      // ---- wind-down: collect what is owed, then watch for strays ----
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d pushes and %0d clears across %0d phases, %0d register writes",
               pushes, clears, phase, csr_writes);
      $display("%0d answers compared, %0d mismatches", board.answers_checked,
               board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sliding_window_progress_check_core.f */
+incdir+rtl/core
rtl/core/swpc_pkg.sv
rtl/core/swpc_isqrt.sv
rtl/core/swpc_seglen.sv
rtl/core/swpc_window.sv
rtl/core/sliding_window_progress_check_core.sv
verif/sliding_window_progress_check_core_tb.sv
